// ----- rtl/core/mefu_pkg.sv -----
`default_nettype none

package mefu_pkg;

	// Motor slots and the bus-side frame fields
	localparam int MOTOR_COUNT_DEF = 4;
	localparam int MOTOR_ID_W      = 2;
	localparam int WORD_W          = 16;

	// Encoder geometry: one turn is a power of two, so a turn is a shift
	localparam int COUNTS_PER_TURN = 8192;
	localparam int TURN_SHIFT      = $clog2(COUNTS_PER_TURN);

	// Offset averaging window; a power of two, so the average is a shift
	localparam int SETTLE_FRAMES   = 256;
	localparam int SETTLE_SHIFT    = $clog2(SETTLE_FRAMES);
	localparam int FRAMES_W        = $clog2(SETTLE_FRAMES + 2);

	// Result and state widths
	localparam int POS_W   = 29;
	localparam int SPEED_W = 18;
	localparam int HIST_W  = 17;
	localparam int REV_W   = 16;
	localparam int ACC_W   = 25;

	// Thresholds
	localparam int DIFF_WRAP_LIMIT   = 5000;
	localparam int OFFS_WRAP_LIMIT   = 6000;
	localparam int SPEED_ROLLOVER    = 16384;
	localparam int SPEED_GUARD       = 3000;
	localparam int TARGET_DEADBAND   = 10;

	typedef enum logic {
		MODE_DIFF   = 1'b0,
		MODE_OFFSET = 1'b1
	} enc_mode_t;

endpackage

`default_nettype wire

// ----- rtl/core/motor_encoder_feedback_unwrap_unit.sv -----
`default_nettype none

// Multi-turn position, turn count and velocity tracker for up to MOTOR_COUNT
// motors fed with 13-bit encoder feedback frames. Each input beat updates the
// state of the motor it addresses and yields one result beat via the input and
// result registers, held in the input register while the last result is not
// taken; a beat for a motor at or beyond MOTOR_COUNT is dropped with no
// result. Throughput is one beat per cycle while each result is taken, back
// to back, even to the same motor: the per-motor state is read and written
// between the input and result registers, so the next beat always sees the
// update. cfg_write_data sets the mode: in difference mode the raw angle is
// the position, moved by a turn that is counted on a jump of more than 5000
// counts, and both current words pass through; in offset mode the first
// SETTLE_FRAMES frames of each motor build an averaged offset, later frames
// subtract it and unwrap at 6000 counts, and the speed result sums the last
// two corrected speed words. Change the mode only while the block is idle.
// Reset clears all per-motor state at once; no start-up sweep is needed.
module motor_encoder_feedback_unwrap_unit #(
	parameter int MOTOR_COUNT = mefu_pkg::MOTOR_COUNT_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration
	input  wire logic                                  cfg_write_en,
	input  wire logic                                  cfg_write_data,
	// input channel
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [mefu_pkg::MOTOR_ID_W-1:0]       motor_index,
	input  wire logic [mefu_pkg::WORD_W-1:0]           angle_raw,
	input  wire logic [mefu_pkg::WORD_W-1:0]           second_word,
	input  wire logic [mefu_pkg::WORD_W-1:0]           third_word,
	input  wire logic signed [mefu_pkg::WORD_W-1:0]    target_speed,
	// result channel
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [mefu_pkg::MOTOR_ID_W-1:0]            motor_out_index,
	output logic signed [mefu_pkg::POS_W-1:0]          unwrapped_position,
	output logic signed [mefu_pkg::SPEED_W-1:0]        speed_estimate,
	output logic signed [mefu_pkg::REV_W-1:0]          turn_count,
	output logic [mefu_pkg::WORD_W-1:0]                measured_current,
	output logic [mefu_pkg::WORD_W-1:0]                commanded_current
);

	localparam int SLOT_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int POS_W  = mefu_pkg::POS_W;
	localparam int DIF_W  = mefu_pkg::POS_W + 2;
	localparam int ACC_W  = mefu_pkg::ACC_W;
	localparam int HIST_W = mefu_pkg::HIST_W;
	localparam int REV_W  = mefu_pkg::REV_W;
	localparam int FR_W   = mefu_pkg::FRAMES_W;
	localparam int W_W    = mefu_pkg::WORD_W;

	// ---------------------------------------------------------------
	// Configuration
	// ---------------------------------------------------------------
	mefu_pkg::enc_mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mefu_pkg::MODE_DIFF;
		end else if (cfg_write_en) begin
			mode_q <= mefu_pkg::enc_mode_t'(cfg_write_data);
		end
	end

	// ---------------------------------------------------------------
	// Input register (stage 1)
	// ---------------------------------------------------------------
	logic                          valid_s1;
	logic [mefu_pkg::MOTOR_ID_W-1:0] idx_s1;
	logic [W_W-1:0]                raw_s1;
	logic [W_W-1:0]                w2_s1;
	logic [W_W-1:0]                w3_s1;
	logic signed [W_W-1:0]         tgt_s1;

	logic hit_s1;
	logic advance;
	logic update;

	logic                          out_valid_s2;

	// A beat for an absent motor simply leaves stage 1 with no result
	assign hit_s1  = ({1'b0, idx_s1} < 3'(MOTOR_COUNT));
	assign advance = valid_s1 && (!hit_s1 || !out_valid_s2 || out_ready);
	assign update  = advance && hit_s1;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			idx_s1 <= motor_index;
			raw_s1 <= angle_raw;
			w2_s1  <= second_word;
			w3_s1  <= third_word;
			tgt_s1 <= target_speed;
		end
	end

	// ---------------------------------------------------------------
	// Per-motor state
	// ---------------------------------------------------------------
	logic signed [POS_W-1:0]            pos_now_q  [MOTOR_COUNT];
	logic signed [REV_W-1:0]            rev_q      [MOTOR_COUNT];
	logic signed [ACC_W-1:0]            acc_q      [MOTOR_COUNT];
	logic [FR_W-1:0]                    frames_q   [MOTOR_COUNT];
	logic signed [HIST_W-1:0]           hist0_q    [MOTOR_COUNT];
	logic signed [HIST_W-1:0]           hist1_q    [MOTOR_COUNT];
	logic                               hslot_q    [MOTOR_COUNT];

	logic [SLOT_W-1:0] slot;
	assign slot = idx_s1[SLOT_W-1:0];

	// Current state of the addressed motor
	logic signed [POS_W-1:0]            prev;
	logic signed [REV_W-1:0]            rev;
	logic signed [ACC_W-1:0]            acc;
	logic [FR_W-1:0]                    frames;
	logic signed [HIST_W-1:0]           hist0;
	logic signed [HIST_W-1:0]           hist1;
	logic                               hslot;

	assign prev   = pos_now_q[slot];
	assign rev    = rev_q[slot];
	assign acc    = acc_q[slot];
	assign frames = frames_q[slot];
	assign hist0  = hist0_q[slot];
	assign hist1  = hist1_q[slot];
	assign hslot  = hslot_q[slot];

	// Frame counter saturates one past the settle window in both modes
	logic [FR_W-1:0] frames_nx;
	logic            settled;
	assign frames_nx = (frames < FR_W'(mefu_pkg::SETTLE_FRAMES + 1)) ?
		frames + FR_W'(1) : frames;
	assign settled   = (frames_nx > FR_W'(mefu_pkg::SETTLE_FRAMES));

	// ---------------------------------------------------------------
	// Difference mode: raw angle against the last position
	// ---------------------------------------------------------------
	logic signed [DIF_W-1:0] raw_ext;
	logic signed [DIF_W-1:0] prev_ext;
	logic signed [DIF_W-1:0] vel0;
	logic signed [DIF_W-1:0] pos0;
	logic signed [DIF_W-1:0] vel0_adj;
	logic signed [REV_W-1:0] rev0;

	assign raw_ext  = $signed({{(DIF_W-W_W){1'b0}}, raw_s1});
	assign prev_ext = $signed({{(DIF_W-POS_W){prev[POS_W-1]}}, prev});
	assign vel0     = raw_ext - prev_ext;

	always_comb begin
		pos0     = raw_ext;
		vel0_adj = vel0;
		rev0     = rev;
		if (vel0 > DIF_W'(mefu_pkg::DIFF_WRAP_LIMIT)) begin
			// forward jump across zero: one turn backwards
			rev0     = rev - REV_W'(1);
			pos0     = raw_ext - DIF_W'(mefu_pkg::COUNTS_PER_TURN);
			vel0_adj = vel0 - DIF_W'(mefu_pkg::COUNTS_PER_TURN);
		end else if (vel0 < -DIF_W'(mefu_pkg::DIFF_WRAP_LIMIT)) begin
			rev0     = rev + REV_W'(1);
			pos0     = raw_ext + DIF_W'(mefu_pkg::COUNTS_PER_TURN);
			vel0_adj = vel0 + DIF_W'(mefu_pkg::COUNTS_PER_TURN);
		end
	end

	// ---------------------------------------------------------------
	// Offset mode
	// ---------------------------------------------------------------
	logic signed [POS_W-1:0] base1;
	logic signed [POS_W-1:0] pos1a;
	logic signed [POS_W-1:0] pos1;
	logic signed [DIF_W-1:0] d1;
	logic signed [REV_W-1:0] rev1;

	// Turns scale by a power of two: append zero bits, wrap at POS_W
	assign base1 = POS_W'({rev, {mefu_pkg::TURN_SHIFT{1'b0}}}) +
		POS_W'(raw_s1);
	assign pos1a = settled ?
		base1 - POS_W'(acc) : base1;
	assign d1    = $signed({{(DIF_W-POS_W){pos1a[POS_W-1]}}, pos1a}) - prev_ext;

	always_comb begin
		pos1 = pos1a;
		rev1 = rev;
		if (settled) begin
			if (d1 < -DIF_W'(mefu_pkg::OFFS_WRAP_LIMIT)) begin
				rev1 = rev + REV_W'(1);
				pos1 = pos1a + POS_W'(mefu_pkg::COUNTS_PER_TURN);
			end else if (d1 > DIF_W'(mefu_pkg::OFFS_WRAP_LIMIT)) begin
				rev1 = rev - REV_W'(1);
				pos1 = pos1a - POS_W'(mefu_pkg::COUNTS_PER_TURN);
			end
		end
	end

	// Speed word: undo a rollover of 16384 that contradicts the target sign
	logic signed [HIST_W-1:0] nv;
	logic signed [HIST_W-1:0] nv_fix;
	logic signed [HIST_W-1:0] hist0_nx;
	logic signed [HIST_W-1:0] hist1_nx;
	logic signed [mefu_pkg::SPEED_W-1:0] sum1;

	assign nv = $signed({w2_s1[W_W-1], w2_s1});

	always_comb begin
		nv_fix = nv;
		if (tgt_s1 > W_W'(mefu_pkg::TARGET_DEADBAND) &&
				nv < -HIST_W'(mefu_pkg::SPEED_GUARD)) begin
			nv_fix = nv + HIST_W'(mefu_pkg::SPEED_ROLLOVER);
		end else if (tgt_s1 < -W_W'(mefu_pkg::TARGET_DEADBAND) &&
				nv > HIST_W'(mefu_pkg::SPEED_GUARD)) begin
			nv_fix = nv - HIST_W'(mefu_pkg::SPEED_ROLLOVER);
		end
	end

	assign hist0_nx = hslot ? hist0 : nv_fix;
	assign hist1_nx = hslot ? nv_fix : hist1;
	assign sum1     = {hist0_nx[HIST_W-1], hist0_nx} + {hist1_nx[HIST_W-1], hist1_nx};

	// Offset accumulation, then truncating average at the end of the window
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ACC_W-1:0] acc_bias;
	logic signed [ACC_W-1:0] acc_avg;
	logic signed [ACC_W-1:0] acc1;

	assign acc_sum  = acc + pos1a[ACC_W-1:0];
	// bias negative sums so the shift rounds towards zero
	assign acc_bias = acc_sum[ACC_W-1] ?
		acc_sum + ACC_W'(mefu_pkg::SETTLE_FRAMES - 1) : acc_sum;
	assign acc_avg  = acc_bias >>> mefu_pkg::SETTLE_SHIFT;
	assign acc1     = settled ? acc :
		((frames_nx == FR_W'(mefu_pkg::SETTLE_FRAMES)) ? acc_avg : acc_sum);

	// ---------------------------------------------------------------
	// Mode select
	// ---------------------------------------------------------------
	logic signed [POS_W-1:0]             pos_nx;
	logic signed [REV_W-1:0]             rev_nx;
	logic signed [mefu_pkg::SPEED_W-1:0] speed_nx;
	logic [W_W-1:0]                      meas_nx;
	logic [W_W-1:0]                      cmd_nx;
	logic                                offset_mode;

	always_comb begin
		case (mode_q)
			mefu_pkg::MODE_OFFSET: begin
				offset_mode = 1'b1;
				pos_nx      = pos1;
				rev_nx      = rev1;
				speed_nx    = sum1;
				meas_nx     = '0;
				cmd_nx      = '0;
			end
			default: begin
				offset_mode = 1'b0;
				pos_nx      = pos0[POS_W-1:0];
				rev_nx      = rev0;
				speed_nx    = vel0_adj[mefu_pkg::SPEED_W-1:0];
				meas_nx     = w2_s1;
				cmd_nx      = w3_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				pos_now_q[m] <= '0;
				rev_q[m]     <= '0;
				acc_q[m]     <= '0;
				frames_q[m]  <= '0;
				hist0_q[m]   <= '0;
				hist1_q[m]   <= '0;
				hslot_q[m]   <= 1'b0;
			end
		end else if (update) begin
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				if (slot == SLOT_W'(m)) begin
					pos_now_q[m] <= pos_nx;
					rev_q[m]     <= rev_nx;
					frames_q[m]  <= frames_nx;
					// history and offset advance in offset mode only
					if (offset_mode) begin
						acc_q[m]   <= acc1;
						hist0_q[m] <= hist0_nx;
						hist1_q[m] <= hist1_nx;
						hslot_q[m] <= !hslot;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register (stage 2)
	// ---------------------------------------------------------------
	logic [mefu_pkg::MOTOR_ID_W-1:0]       idx_s2;
	logic signed [POS_W-1:0]               pos_s2;
	logic signed [mefu_pkg::SPEED_W-1:0]   speed_s2;
	logic signed [REV_W-1:0]               rev_s2;
	logic [W_W-1:0]                        meas_s2;
	logic [W_W-1:0]                        cmd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (update) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			idx_s2   <= idx_s1;
			pos_s2   <= pos_nx;
			speed_s2 <= speed_nx;
			rev_s2   <= rev_nx;
			meas_s2  <= meas_nx;
			cmd_s2   <= cmd_nx;
		end
	end

	assign out_valid          = out_valid_s2;
	assign motor_out_index    = idx_s2;
	assign unwrapped_position = pos_s2;
	assign speed_estimate     = speed_s2;
	assign turn_count         = rev_s2;
	assign measured_current   = meas_s2;
	assign commanded_current  = cmd_s2;

endmodule

`default_nettype wire
